// ----- hw/rtl/timer_deadline_queue_macros.svh -----
// Assertion macros used by the timer deadline queue datapath.
`ifndef TIMER_DEADLINE_QUEUE_MACROS_SVH
`define TIMER_DEADLINE_QUEUE_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define TDQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("timer_deadline_queue: assertion failed");

// Condition must never be true outside reset.
`define TDQ_NEVER(lbl, cond) \
  `TDQ_ASSERT(lbl, !(cond))

`endif

// ----- hw/rtl/tdq_pkg.sv -----
// Shared types and codes of the timer deadline queue.
package tdq_pkg;

  // Operation codes of an input beat.
  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_DELETE   = 2'd1;
  localparam logic [1:0] OP_DISPATCH = 2'd2;
  localparam logic [1:0] OP_NONE     = 2'd3;

  // Result kinds.
  localparam logic [2:0] KIND_FIRED   = 3'd0;
  localparam logic [2:0] KIND_WAIT    = 3'd1;
  localparam logic [2:0] KIND_EMPTY   = 3'd2;
  localparam logic [2:0] KIND_DONE    = 3'd3;
  localparam logic [2:0] KIND_BUSY    = 3'd4;
  localparam logic [2:0] KIND_NOTPEND = 3'd5;

  localparam logic [30:0] WAIT_SAT = 31'h7FFF_FFFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic mv_init;
    logic mv;
    logic fin;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       hit;
    logic       full;
    logic       scan_done;
    logic       move_done;
  } status_t;

endpackage

// ----- hw/rtl/tdq_ram.sv -----
// Generic simple dual-port RAM with registered read.
module tdq_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hw/rtl/tdq_ctrl.sv -----
// Controller state machine of the timer deadline queue.
module tdq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [1:0]      operation_i,
  input  tdq_pkg::status_t status_i,
  output tdq_pkg::cmd_t   cmd_o,
  output logic            busy_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_MOVE = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       go_move;

  // Decide whether the table must be shifted after the scan.
  assign go_move = ((status_i.op == tdq_pkg::OP_ADD) && !status_i.hit && !status_i.full) ||
                   ((status_i.op == tdq_pkg::OP_DELETE) && status_i.hit) ||
                   (status_i.op == tdq_pkg::OP_DISPATCH);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (operation_i != tdq_pkg::OP_NONE) begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) begin
          if (go_move) begin
            cmd_o.mv_init = 1'b1;
            state_d       = S_MOVE;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_MOVE: begin
        cmd_o.mv = 1'b1;
        if (status_i.move_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ----- hw/rtl/tdq_dp.sv -----
// Datapath of the timer deadline queue: table RAM, scan and shift logic, results.
`include "timer_deadline_queue_macros.svh"

module tdq_dp #(
  parameter int ENTRIES = 16,
  parameter int ID_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tdq_pkg::cmd_t    cmd_i,
  output tdq_pkg::status_t status_o,
  input  logic [1:0]       operation_i,
  input  logic [7:0]       event_id_i,
  input  logic [31:0]      delay_ms_i,
  input  logic [63:0]      now_ms_i,
  input  logic             max_delay_we_i,
  input  logic [31:0]      max_delay_i,
  output logic             result_valid_o,
  output logic [2:0]       result_kind_o,
  output logic [7:0]       result_id_o,
  output logic [30:0]      wait_ms_o,
  output logic             last_o
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int WW = 64 + ID_BITS;

  // Captured item.
  logic [1:0]         op_q;
  logic [ID_BITS-1:0] id_q;
  logic [63:0]        now_q, dl_q;
  logic [31:0]        max_delay_q;

  // Table and walk state.
  logic [CW-1:0] count_q, ptr_q, pidx_q, pos_q, popped_q, off_q;
  logic          pv_q, hit_q, posf_q, stop_q;
  logic [30:0]   wait_q;

  // Result registers.
  logic          out_v_q, out_last_q;
  logic [2:0]    out_kind_q;
  logic [7:0]    out_id_q;
  logic [30:0]   out_wait_q;

  // Combinational helpers.
  logic [ID_BITS+7:0] id_ext_in, id_ext_q, id_ext_rd;
  logic [ID_BITS-1:0] id_in;
  logic [31:0]        delay_eff;
  logic [63:0]        dl_sum;
  logic               ram_we;
  logic [CW-1:0]      wr_idx, rd_idx;
  logic [WW-1:0]      ram_wdata, ram_rdata;
  logic [63:0]        rd_dl, ins_diff, now_diff, wait_diff;
  logic [ID_BITS-1:0] rd_id;
  logic               scan_issue, desc, mv_issue, add_ok;

  // Input id taken modulo the id width.
  assign id_ext_in = {{ID_BITS{1'b0}}, event_id_i};
  assign id_in     = id_ext_in[ID_BITS-1:0];
  assign id_ext_q  = {8'd0, id_q};
  assign id_ext_rd = {8'd0, rd_id};

  // Deadline of a new timer: clamped delay added to now, zero becomes all ones.
  assign delay_eff = (delay_ms_i > max_delay_q) ? max_delay_q : delay_ms_i;
  assign dl_sum    = now_ms_i + {32'd0, delay_eff};

  // Entry read back from the table.
  assign rd_dl     = ram_rdata[WW-1:ID_BITS];
  assign rd_id     = ram_rdata[ID_BITS-1:0];
  assign ins_diff  = dl_q - rd_dl;
  assign now_diff  = now_q - rd_dl;
  assign wait_diff = rd_dl - now_q;

  // Read sequencing for the scan and for the shift pass.
  assign scan_issue = ptr_q < count_q;
  assign desc       = (op_q == tdq_pkg::OP_ADD);
  assign mv_issue   = desc ? (ptr_q > pos_q) : (ptr_q < count_q);
  assign rd_idx     = (cmd_i.mv && desc) ? (ptr_q - CW'(1)) : ptr_q;
  assign add_ok     = (op_q == tdq_pkg::OP_ADD) && !hit_q && (count_q != CW'(ENTRIES));

  // Write port: shifted entries, then the new entry of an add.
  assign ram_we    = (cmd_i.mv && pv_q) || (cmd_i.fin && add_ok);
  assign wr_idx    = cmd_i.mv ? pidx_q : pos_q;
  assign ram_wdata = cmd_i.mv ? ram_rdata : {dl_q, id_q};

  tdq_ram #(
    .WIDTH(WW),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_idx[IW-1:0]),
    .wdata_i(ram_wdata),
    .raddr_i(rd_idx[IW-1:0]),
    .rdata_o(ram_rdata)
  );

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_delay_q <= '1;
    end else if (max_delay_we_i) begin
      max_delay_q <= max_delay_i;
    end
  end

  // Payload captured at the start of an item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= operation_i;
      id_q  <= id_in;
      now_q <= now_ms_i;
      dl_q  <= (dl_sum == 64'd0) ? '1 : dl_sum;
    end
  end

  // Walk control, scan results and table count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      ptr_q    <= '0;
      pidx_q   <= '0;
      pos_q    <= '0;
      popped_q <= '0;
      off_q    <= '0;
      pv_q     <= 1'b0;
      hit_q    <= 1'b0;
      posf_q   <= 1'b0;
      stop_q   <= 1'b0;
      wait_q   <= '0;
    end else begin
      pv_q <= 1'b0;
      if (cmd_i.load) begin
        ptr_q    <= '0;
        pos_q    <= count_q;
        popped_q <= '0;
        hit_q    <= 1'b0;
        posf_q   <= 1'b0;
        stop_q   <= 1'b0;
      end
      if (cmd_i.scan && !cmd_i.mv_init && scan_issue) begin
        pv_q   <= 1'b1;
        pidx_q <= ptr_q;
        ptr_q  <= ptr_q + CW'(1);
      end
      // Evaluate one returned entry of the scan.
      if (cmd_i.scan && pv_q) begin
        case (op_q)
          tdq_pkg::OP_ADD: begin
            if (rd_id == id_q) begin
              hit_q <= 1'b1;
            end
            if (!posf_q && ins_diff[63]) begin
              posf_q <= 1'b1;
              pos_q  <= pidx_q;
            end
          end
          tdq_pkg::OP_DELETE: begin
            if (!hit_q && (rd_id == id_q)) begin
              hit_q <= 1'b1;
              pos_q <= pidx_q;
            end
          end
          tdq_pkg::OP_DISPATCH: begin
            if (!stop_q) begin
              if (now_diff[63]) begin
                stop_q <= 1'b1;
                wait_q <= (wait_diff[63:31] != '0) ? tdq_pkg::WAIT_SAT : wait_diff[30:0];
              end else begin
                popped_q <= popped_q + CW'(1);
              end
            end
          end
          default: begin
          end
        endcase
      end
      // Set up the shift pass.
      if (cmd_i.mv_init) begin
        case (op_q)
          tdq_pkg::OP_ADD: begin
            ptr_q <= count_q;
          end
          tdq_pkg::OP_DELETE: begin
            ptr_q <= pos_q + CW'(1);
            off_q <= CW'(1);
          end
          default: begin
            ptr_q <= popped_q;
            off_q <= popped_q;
          end
        endcase
      end
      // One read per cycle, written back in the following cycle.
      if (cmd_i.mv && mv_issue) begin
        pv_q <= 1'b1;
        if (desc) begin
          ptr_q  <= ptr_q - CW'(1);
          pidx_q <= ptr_q;
        end else begin
          ptr_q  <= ptr_q + CW'(1);
          pidx_q <= ptr_q - off_q;
        end
      end
      // Commit the new count.
      if (cmd_i.fin) begin
        if (add_ok) begin
          count_q <= count_q + CW'(1);
        end else if ((op_q == tdq_pkg::OP_DELETE) && hit_q) begin
          count_q <= count_q - CW'(1);
        end else if (op_q == tdq_pkg::OP_DISPATCH) begin
          count_q <= count_q - popped_q;
        end
      end
    end
  end

  // Result beat register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
      out_kind_q <= tdq_pkg::KIND_FIRED;
      out_id_q   <= '0;
      out_wait_q <= '0;
    end else begin
      out_v_q <= 1'b0;
      if (cmd_i.scan && pv_q && (op_q == tdq_pkg::OP_DISPATCH) && !stop_q && !now_diff[63]) begin
        out_v_q    <= 1'b1;
        out_last_q <= 1'b0;
        out_kind_q <= tdq_pkg::KIND_FIRED;
        out_id_q   <= id_ext_rd[7:0];
        out_wait_q <= '0;
      end
      if (cmd_i.fin) begin
        out_v_q    <= 1'b1;
        out_last_q <= 1'b1;
        out_id_q   <= id_ext_q[7:0];
        out_wait_q <= '0;
        case (op_q)
          tdq_pkg::OP_ADD: begin
            out_kind_q <= add_ok ? tdq_pkg::KIND_DONE : tdq_pkg::KIND_BUSY;
          end
          tdq_pkg::OP_DELETE: begin
            out_kind_q <= hit_q ? tdq_pkg::KIND_DONE : tdq_pkg::KIND_NOTPEND;
          end
          default: begin
            out_id_q <= '0;
            if (stop_q) begin
              out_kind_q <= tdq_pkg::KIND_WAIT;
              out_wait_q <= wait_q;
            end else begin
              out_kind_q <= tdq_pkg::KIND_EMPTY;
            end
          end
        endcase
      end
    end
  end

  assign result_valid_o = out_v_q;
  assign result_kind_o  = out_kind_q;
  assign result_id_o    = out_id_q;
  assign wait_ms_o      = out_wait_q;
  assign last_o         = out_last_q;

  // Status to the controller.
  assign status_o.op        = op_q;
  assign status_o.hit       = hit_q;
  assign status_o.full      = (count_q == CW'(ENTRIES));
  assign status_o.scan_done = !scan_issue && !pv_q;
  assign status_o.move_done = !mv_issue && !pv_q;

  `TDQ_ASSERT(a_count_bound, count_q <= CW'(ENTRIES))
  `TDQ_ASSERT(a_write_range, ram_we |-> (wr_idx < CW'(ENTRIES)))
  `TDQ_NEVER(a_fired_not_last, out_v_q && (out_kind_q == tdq_pkg::KIND_FIRED) && out_last_q)

endmodule

// ----- hw/rtl/timer_deadline_queue.sv -----
// Top level of the timer deadline queue: controller plus datapath.
//
// Keeps up to ENTRIES timers sorted by deadline in a single-port-write RAM.
// An item is taken when start_i is high and busy_o is low; results leave as
// one-cycle beats on result_valid_o and cannot be stalled, with last_o on the
// final beat of each item. Every add, delete and dispatch first scans the
// pending entries one per cycle, then, unless an add or delete leaves the
// table unchanged, shifts the affected part of the table one entry per cycle
// through the RAM's one read and one write port. The final beat appears in
// the first cycle with busy_o low. Fired beats of a dispatch come out during
// its scan. Operation code 3 gives no result and leaves busy_o low. The table
// needs no clearing after reset; max_delay_i may be written whenever busy_o
// is low.
module timer_deadline_queue #(
  parameter int ENTRIES = 16,
  parameter int ID_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  event_id_i,
  input  logic [31:0] delay_ms_i,
  input  logic [63:0] now_ms_i,
  input  logic        max_delay_we_i,
  input  logic [31:0] max_delay_i,
  output logic        result_valid_o,
  output logic [2:0]  result_kind_o,
  output logic [7:0]  result_id_o,
  output logic [30:0] wait_ms_o,
  output logic        last_o
);

  tdq_pkg::cmd_t    cmd;
  tdq_pkg::status_t status;

  tdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .operation_i(operation_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy_o)
  );

  tdq_dp #(
    .ENTRIES(ENTRIES),
    .ID_BITS(ID_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .operation_i   (operation_i),
    .event_id_i    (event_id_i),
    .delay_ms_i    (delay_ms_i),
    .now_ms_i      (now_ms_i),
    .max_delay_we_i(max_delay_we_i),
    .max_delay_i   (max_delay_i),
    .result_valid_o(result_valid_o),
    .result_kind_o (result_kind_o),
    .result_id_o   (result_id_o),
    .wait_ms_o     (wait_ms_o),
    .last_o        (last_o)
  );

endmodule
